// ----- rtl/core/kbeu_pkg.sv -----
// Shared types, codes and helper functions for the knob and button event unit.
package kbeu_pkg;

    // Event queue geometry
    localparam int QUEUE_DEPTH = 8;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int LVL_W       = (PTR_W + 1 > 4) ? PTR_W + 1 : 4;
    localparam int PEND_MAX    = 7;
    localparam int PUSH_SLOTS  = 4;
    localparam int NUM_BUTTONS = 3;

    // Command codes
    localparam logic [1:0] CMD_INIT   = 2'd0;
    localparam logic [1:0] CMD_UPDATE = 2'd1;
    localparam logic [1:0] CMD_POP    = 2'd2;
    localparam logic [1:0] CMD_CLEAR  = 2'd3;

    // Event codes
    localparam logic [2:0] EV_NONE  = 3'd0;
    localparam logic [2:0] EV_OK    = 3'd1;
    localparam logic [2:0] EV_BACK  = 3'd2;
    localparam logic [2:0] EV_START = 3'd3;
    localparam logic [2:0] EV_RIGHT = 3'd4;
    localparam logic [2:0] EV_LEFT  = 3'd5;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_MS  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DETENT_STEPS = 1'd1;

    localparam logic [15:0] DEBOUNCE_MS_RST  = 16'd20;
    localparam logic [2:0]  DETENT_STEPS_RST = 3'd4;

    typedef logic [PTR_W-1:0] t_ptr;

    typedef struct packed {
        logic [1:0]  cmd;
        logic        enc_a_level;
        logic        enc_b_level;
        logic        ok_level;
        logic        back_level;
        logic        start_level;
        logic [31:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic [2:0] event_res;
        logic [2:0] pending_count;
    } t_out_item;

    // Per-transfer strobes, already qualified by the pipeline advance
    typedef struct packed {
        logic init;
        logic update;
        logic pop;
        logic clear;
    } t_step_ctl;

    // Up to four queue writes per update: knob, OK, back, start in that order
    typedef struct packed {
        logic [PUSH_SLOTS-1:0]      valid;
        logic [PUSH_SLOTS-1:0][2:0] ev;
    } t_push_req;

    // Gray-code transition decode, index is {previous, current}
    function automatic logic signed [1:0] gray_delta(input logic [3:0] idx);
        logic signed [1:0] d;
        case (idx)
            4'h1, 4'h7, 4'h8, 4'hE: d = -2'sd1;
            4'h2, 4'h4, 4'hB, 4'hD: d = 2'sd1;
            default:                d = 2'sd0;
        endcase
        return d;
    endfunction

    function automatic t_ptr ptr_inc(input t_ptr p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

endpackage

// ----- rtl/core/kbeu_knob.sv -----
// Quadrature knob decoder: step counter and detent event generation.
module kbeu_knob (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  kbeu_pkg::t_step_ctl  i_ctl,
    input  logic [1:0]           i_quad,
    input  logic [2:0]           i_detent_steps,
    output logic                 o_push,
    output logic [2:0]           o_event
);

    logic [1:0]        r_prev_quad;
    logic signed [3:0] r_step_count;
    logic [1:0]        n_prev_quad;
    logic signed [3:0] n_step_count;

    logic signed [1:0] delta;
    logic signed [4:0] sum;
    logic signed [4:0] lim;

    always_comb begin
        delta        = kbeu_pkg::gray_delta({r_prev_quad, i_quad});
        sum          = 5'(r_step_count) + 5'(delta);
        lim          = $signed({2'b00, i_detent_steps});
        n_prev_quad  = r_prev_quad;
        n_step_count = r_step_count;
        o_push       = 1'b0;
        o_event      = kbeu_pkg::EV_NONE;
        if (i_ctl.init) begin
            n_prev_quad  = i_quad;
            n_step_count = '0;
        end else if (i_ctl.update) begin
            n_prev_quad = i_quad;
            if (delta != 2'sd0) begin
                if (sum >= lim) begin
                    n_step_count = '0;
                    o_push       = 1'b1;
                    o_event      = kbeu_pkg::EV_RIGHT;
                end else if (sum <= -lim) begin
                    n_step_count = '0;
                    o_push       = 1'b1;
                    o_event      = kbeu_pkg::EV_LEFT;
                end else begin
                    n_step_count = sum[3:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_quad  <= '0;
            r_step_count <= '0;
        end else begin
            r_prev_quad  <= n_prev_quad;
            r_step_count <= n_step_count;
        end
    end

endmodule

// ----- rtl/core/kbeu_debounce.sv -----
// Debounce of one button, given as an active-high pressed level, against a wrapping millisecond time.
module kbeu_debounce (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  kbeu_pkg::t_step_ctl  i_ctl,
    input  logic                 i_pressed,
    input  logic [31:0]          i_now_ms,
    input  logic [15:0]          i_debounce_ms,
    output logic                 o_press
);

    logic        r_raw;
    logic        r_stable;
    logic [31:0] r_change_time;
    logic        n_raw;
    logic        n_stable;
    logic [31:0] n_change_time;

    logic [31:0] elapsed;

    always_comb begin
        elapsed       = i_now_ms - r_change_time;
        n_raw         = r_raw;
        n_stable      = r_stable;
        n_change_time = r_change_time;
        o_press       = 1'b0;
        if (i_ctl.init) begin
            n_raw         = i_pressed;
            n_stable      = i_pressed;
            n_change_time = i_now_ms;
        end else if (i_ctl.update) begin
            if (i_pressed != r_raw) begin
                n_raw         = i_pressed;
                n_change_time = i_now_ms;
            end else if (i_pressed != r_stable && elapsed >= {16'd0, i_debounce_ms}) begin
                n_stable = i_pressed;
                o_press  = i_pressed;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw         <= 1'b0;
            r_stable      <= 1'b0;
            r_change_time <= '0;
        end else begin
            r_raw         <= n_raw;
            r_stable      <= n_stable;
            r_change_time <= n_change_time;
        end
    end

endmodule

// ----- rtl/core/kbeu_queue.sv -----
// Ring queue of events: up to four pushes per update, oldest dropped when full.
module kbeu_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  kbeu_pkg::t_step_ctl  i_ctl,
    input  kbeu_pkg::t_push_req  i_push,
    output logic [2:0]           o_event_res,
    output logic [2:0]           o_pending_count
);

    logic [2:0]     r_store [kbeu_pkg::QUEUE_DEPTH];
    logic [2:0]     n_store [kbeu_pkg::QUEUE_DEPTH];
    kbeu_pkg::t_ptr r_rd_ptr;
    kbeu_pkg::t_ptr r_wr_ptr;
    kbeu_pkg::t_ptr n_rd_ptr;
    kbeu_pkg::t_ptr n_wr_ptr;

    kbeu_pkg::t_ptr                nxt;
    logic [kbeu_pkg::LVL_W-1:0]    level;

    always_comb begin
        n_store     = r_store;
        n_rd_ptr    = r_rd_ptr;
        n_wr_ptr    = r_wr_ptr;
        nxt         = r_wr_ptr;
        o_event_res = kbeu_pkg::EV_NONE;
        if (i_ctl.init || i_ctl.clear) begin
            n_rd_ptr = '0;
            n_wr_ptr = '0;
        end else if (i_ctl.pop) begin
            if (r_rd_ptr != r_wr_ptr) begin
                o_event_res = r_store[r_rd_ptr];
                n_rd_ptr    = kbeu_pkg::ptr_inc(r_rd_ptr);
            end
        end else if (i_ctl.update) begin
            // pushes apply in slot order; a full queue gives up its oldest entry
            for (int k = 0; k < kbeu_pkg::PUSH_SLOTS; k++) begin
                if (i_push.valid[k]) begin
                    nxt = kbeu_pkg::ptr_inc(n_wr_ptr);
                    if (nxt == n_rd_ptr) begin
                        n_rd_ptr = kbeu_pkg::ptr_inc(n_rd_ptr);
                    end
                    n_store[n_wr_ptr] = i_push.ev[k];
                    n_wr_ptr          = nxt;
                end
            end
        end
    end

    always_comb begin
        if (n_wr_ptr >= n_rd_ptr) begin
            level = kbeu_pkg::LVL_W'(n_wr_ptr) - kbeu_pkg::LVL_W'(n_rd_ptr);
        end else begin
            level = kbeu_pkg::LVL_W'(n_wr_ptr) + kbeu_pkg::LVL_W'(kbeu_pkg::QUEUE_DEPTH)
                  - kbeu_pkg::LVL_W'(n_rd_ptr);
        end
        if (level > kbeu_pkg::LVL_W'(kbeu_pkg::PEND_MAX)) begin
            o_pending_count = 3'(kbeu_pkg::PEND_MAX);
        end else begin
            o_pending_count = level[2:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_store <= n_store;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
        end else begin
            r_rd_ptr <= n_rd_ptr;
            r_wr_ptr <= n_wr_ptr;
        end
    end

endmodule

// ----- rtl/core/knob_and_button_event_unit_core.sv -----
// Top level of the knob and button event unit: input register, step logic, result register.
//
//  channel   | direction | handshake                  | payload
//  ----------+-----------+----------------------------+----------------------------
//  input     | in        | i_in_valid / o_in_stall    | i_in_data  (t_in_item)
//  result    | out       | o_out_valid / i_out_stall  | o_out_data (t_out_item)
//  config    | in        | i_cfg_we                   | i_cfg_idx, i_cfg_data
//
//  One item per cycle sustained while the result side does not stall; a result is offered
//  after its input passes the input register, then the result register. The single step
//  of state logic between them is knob decode, three debouncers and a queue with four write slots.
//  Reset is synchronous, active low; no clearing pass, items are taken right after reset.
//  A stall on the result side holds the result register, then the input register,
//  and only then raises o_in_stall.
module knob_and_button_event_unit_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  kbeu_pkg::t_in_item                   i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output kbeu_pkg::t_out_item                  o_out_data,
    input  logic                                 i_cfg_we,
    input  logic [kbeu_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [15:0]                          i_cfg_data
);

    logic [15:0]         r_debounce_ms;
    logic [2:0]          r_detent_steps;
    logic                r_armed;
    logic                r_in_valid;
    kbeu_pkg::t_in_item  r_in_data;
    logic                r_out_valid;
    kbeu_pkg::t_out_item r_out_data;

    logic                out_ready;
    logic                fire;
    logic                in_take;
    kbeu_pkg::t_step_ctl ctl;
    kbeu_pkg::t_push_req push;
    logic [1:0]          quad;
    logic [2:0]          pressed;
    logic [2:0]          press;
    logic                knob_push;
    logic [2:0]          knob_event;
    logic [2:0]          event_res;
    logic [2:0]          pending_count;

    assign out_ready  = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && out_ready;
    assign o_in_stall = r_in_valid && !out_ready;
    assign in_take    = i_in_valid && !o_in_stall;

    assign ctl.init   = fire && (r_in_data.cmd == kbeu_pkg::CMD_INIT);
    assign ctl.update = fire && (r_in_data.cmd == kbeu_pkg::CMD_UPDATE) && r_armed;
    assign ctl.pop    = fire && (r_in_data.cmd == kbeu_pkg::CMD_POP);
    assign ctl.clear  = fire && (r_in_data.cmd == kbeu_pkg::CMD_CLEAR);

    // pins are active low
    assign quad    = {~r_in_data.enc_a_level, ~r_in_data.enc_b_level};
    assign pressed = {~r_in_data.start_level, ~r_in_data.back_level, ~r_in_data.ok_level};

    kbeu_knob u_knob (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl),
        .i_quad         (quad),
        .i_detent_steps (r_detent_steps),
        .o_push         (knob_push),
        .o_event        (knob_event)
    );

    for (genvar g = 0; g < kbeu_pkg::NUM_BUTTONS; g++) begin : g_btn
        kbeu_debounce u_debounce (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (ctl),
            .i_pressed     (pressed[g]),
            .i_now_ms      (r_in_data.now_ms),
            .i_debounce_ms (r_debounce_ms),
            .o_press       (press[g])
        );
    end

    assign push.valid = {press[2], press[1], press[0], knob_push};
    assign push.ev    = {kbeu_pkg::EV_START, kbeu_pkg::EV_BACK, kbeu_pkg::EV_OK, knob_event};

    kbeu_queue u_queue (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (ctl),
        .i_push          (push),
        .o_event_res     (event_res),
        .o_pending_count (pending_count)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ms  <= kbeu_pkg::DEBOUNCE_MS_RST;
            r_detent_steps <= kbeu_pkg::DETENT_STEPS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                kbeu_pkg::CFG_DEBOUNCE_MS:  r_debounce_ms  <= i_cfg_data;
                kbeu_pkg::CFG_DETENT_STEPS: r_detent_steps <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed <= 1'b0;
        end else begin
            if (ctl.init) begin
                r_armed <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_data <= i_in_data;
        end
        if (fire) begin
            r_out_data.event_res     <= event_res;
            r_out_data.pending_count <= pending_count;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ----- rtl/core/kbeu_checker.sv -----
// Port-level checker for the knob and button event unit, bound to the top level.
module kbeu_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           o_in_stall,
    input  logic                           o_out_valid,
    input  logic                           i_out_stall,
    input  kbeu_pkg::t_out_item            o_out_data
);

    // results are not held back by reset leftovers
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // input side only stalls behind a full, stalled result stage
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stall without result backpressure");

    a_event_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.event_res <= kbeu_pkg::EV_LEFT))
        else $error("event code out of range");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

endmodule

bind knob_and_button_event_unit_core kbeu_checker u_kbeu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
